/* rtl/cpr_pkg.sv */
// shared types and constants for the command packet receiver
package cpr_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned WORD_W        = 16;
    localparam int unsigned COUNT_W       = 9;
    localparam int unsigned INDEX_W       = 7;
    localparam int unsigned CFG_INDEX_W   = 1;

    localparam logic [COUNT_W-1:0] FULL_PACKET_BYTES = 9'd256;

    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_CMD  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_CMD = 1'b1;

    localparam logic [BYTE_W-1:0] WRITE_CMD_RESET  = 8'd1;
    localparam logic [BYTE_W-1:0] STATUS_CMD_RESET = 8'd2;

    localparam logic FUNC_RX_BYTE  = 1'b0;
    localparam logic FUNC_TX_EMPTY = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_cpr_phase;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] app_status;
    } t_cpr_in;

    typedef struct packed {
        logic               tx_load;
        logic [BYTE_W-1:0]  tx_byte;
        logic               word_write;
        logic [INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]  word_value;
        logic               packet_done;
        logic               packet_kind;
        logic [COUNT_W-1:0] packet_bytes;
        logic               final_packet;
        logic               command_error;
    } t_cpr_out;

    typedef struct packed {
        t_cpr_phase         phase;
        logic [COUNT_W-1:0] expected_bytes;
        logic [COUNT_W-1:0] received_bytes;
        logic [BYTE_W-1:0]  held_low_byte;
        logic               last_length_nonzero;
    } t_cpr_state;

    typedef struct packed {
        logic [BYTE_W-1:0] write_cmd;
        logic [BYTE_W-1:0] status_cmd;
    } t_cpr_cfg;

endpackage

/* rtl/cpr_framer.sv */
// per-transaction framing logic: result and next receive state
module cpr_framer import cpr_pkg::*; (
    input  t_cpr_in    i_in,
    input  t_cpr_state i_state,
    input  t_cpr_cfg   i_cfg,
    output t_cpr_out   o_result,
    output t_cpr_state o_state
);

    logic [COUNT_W-1:0] rcv_inc;
    logic               in_range;
    logic               emit;
    logic [WORD_W-1:0]  word;
    logic               done_data;

    assign rcv_inc  = i_state.received_bytes + COUNT_W'(1);
    assign in_range = (i_state.received_bytes < i_state.expected_bytes);

    always_comb begin
        o_result = '0;
        o_state  = i_state;
        emit      = 1'b0;
        word      = '0;
        done_data = 1'b0;

        if (i_in.func == FUNC_TX_EMPTY) begin
            o_result.tx_load = 1'b1;
            o_result.tx_byte = i_in.app_status;
        end else begin
            unique case (i_state.phase)
                PH_CMD: begin
                    if (i_in.rx_byte == i_cfg.write_cmd) begin
                        o_state.phase = PH_LEN;
                    end else if (i_in.rx_byte == i_cfg.status_cmd) begin
                        o_result.tx_load     = 1'b1;
                        o_result.tx_byte     = i_in.app_status;
                        o_result.packet_done = 1'b1;
                        o_result.packet_kind = KIND_STATUS;
                    end else begin
                        o_result.command_error = 1'b1;
                    end
                end
                PH_LEN: begin
                    o_state.expected_bytes      = (i_in.rx_byte == '0) ? FULL_PACKET_BYTES
                                                  : COUNT_W'(i_in.rx_byte);
                    o_state.last_length_nonzero = (i_in.rx_byte != '0);
                    o_state.received_bytes      = '0;
                    o_state.phase               = PH_DATA;
                end
                PH_DATA: begin
                    if (in_range) begin
                        if (!i_state.received_bytes[0]) begin
                            o_state.held_low_byte = i_in.rx_byte;
                            if (rcv_inc >= i_state.expected_bytes) begin
                                emit = 1'b1;
                                word = WORD_W'(i_in.rx_byte);
                            end
                        end else begin
                            emit = 1'b1;
                            word = {i_in.rx_byte, i_state.held_low_byte};
                        end
                        o_state.received_bytes = rcv_inc;
                    end
                    done_data = (o_state.received_bytes >= i_state.expected_bytes);
                    if (done_data) begin
                        o_state.phase = PH_CMD;
                    end
                    o_result.word_write  = emit;
                    o_result.word_index  = emit ? i_state.received_bytes[INDEX_W:1] : '0;
                    o_result.word_value  = word;
                    o_result.packet_done = done_data;
                    o_result.packet_kind = KIND_WRITE;
                    if (emit || done_data) begin
                        o_result.packet_bytes = i_state.expected_bytes;
                        o_result.final_packet = i_state.last_length_nonzero;
                    end
                end
                default: begin
                    o_state.phase = PH_CMD;
                end
            endcase
        end
    end

endmodule

/* rtl/command_packet_receiver_unit.sv */
// top level of the command packet receiver
//
// input channel: one event per transaction (received byte or transmit-empty),
// with the application status byte offered alongside
// output channel: exactly one result transaction per input transaction
// config port: write enable, register index and data; write only while idle
// latency: a result is presented one cycle after its input transaction
// throughput: one transaction per cycle, set by the single framing stage
// between the receive state registers and the output register
// the output register takes a new result in the same cycle its old one
// leaves, so o_in_stall is high only while a result waits under i_out_stall
// reset: waits for a command byte, counters and held byte clear, command
// codes return to 1 (write) and 2 (status), no result pending
// receiver stall: the result holds and input is stalled until it is taken
module command_packet_receiver_unit import cpr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]      i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_cpr_in                i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_cpr_out               o_out_data
);

    t_cpr_cfg   r_cfg;
    t_cpr_state r_state;
    t_cpr_state n_state;
    t_cpr_out   n_result;
    t_cpr_out   r_out_data;
    logic       r_out_valid;
    logic       in_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    cpr_framer u_framer (
        .i_in     (i_in_data),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_result (n_result),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_cmd  <= WRITE_CMD_RESET;
            r_cfg.status_cmd <= STATUS_CMD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WRITE_CMD:  r_cfg.write_cmd  <= i_cfg_data;
                CFG_STATUS_CMD: r_cfg.status_cmd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_CMD, default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_result;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with empty output register");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transaction produced no result");

    a_data_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DATA) |-> (r_state.received_bytes < r_state.expected_bytes))
        else $error("data phase with byte count at or beyond packet length");

    a_word_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.word_write) |-> (r_out_data.packet_bytes != '0))
        else $error("word emitted without packet length");

    a_status_reply_loads_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.packet_done && r_out_data.packet_kind == KIND_STATUS)
        |-> r_out_data.tx_load)
        else $error("status request completed without transmit load");

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the command packet receiver unit
`timescale 1ns / 1ps

module tb_top;
    import cpr_pkg::*;

    class packet_scoreboard;
        t_cpr_out            expected_q[$];
        logic [BYTE_W-1:0]   write_cmd;
        logic [BYTE_W-1:0]   status_cmd;
        t_cpr_phase          phase;
        logic [COUNT_W-1:0]  expected_bytes;
        logic [COUNT_W-1:0]  received_bytes;
        logic [BYTE_W-1:0]   held_low;
        logic                length_nonzero;
        int                  errors;
        int                  printed;

        function new();
            write_cmd      = WRITE_CMD_RESET;
            status_cmd     = STATUS_CMD_RESET;
            phase          = PH_CMD;
            expected_bytes = '0;
            received_bytes = '0;
            held_low       = '0;
            length_nonzero = 1'b0;
            errors         = 0;
            printed        = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                CFG_WRITE_CMD: begin
                    write_cmd = val;
                end
                CFG_STATUS_CMD: begin
                    status_cmd = val;
                end
                default: begin
                end
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // frames one accepted event and queues the result it must produce
        function void accept_event(t_cpr_in ev);
            t_cpr_out            r;
            logic                emit;
            logic [WORD_W-1:0]   word;
            logic [INDEX_W-1:0]  idx;
            r    = '0;
            emit = 1'b0;
            word = '0;
            idx  = received_bytes[INDEX_W:1];
            if (ev.func == FUNC_TX_EMPTY) begin
                r.tx_load = 1'b1;
                r.tx_byte = ev.app_status;
            end else begin
                case (phase)
                    PH_CMD: begin
                        if (ev.rx_byte == write_cmd) begin
                            phase = PH_LEN;
                        end else if (ev.rx_byte == status_cmd) begin
                            r.tx_load     = 1'b1;
                            r.tx_byte     = ev.app_status;
                            r.packet_done = 1'b1;
                            r.packet_kind = KIND_STATUS;
                        end else begin
                            r.command_error = 1'b1;
                        end
                    end
                    PH_LEN: begin
                        expected_bytes = (ev.rx_byte == '0) ? FULL_PACKET_BYTES
                                                            : {1'b0, ev.rx_byte};
                        length_nonzero = (ev.rx_byte != '0);
                        received_bytes = '0;
                        phase          = PH_DATA;
                    end
                    PH_DATA: begin
                        if (received_bytes < expected_bytes) begin
                            if (!received_bytes[0]) begin
                                held_low = ev.rx_byte;
                                if (received_bytes + 9'd1 >= expected_bytes) begin
                                    emit = 1'b1;
                                    word = {8'h00, ev.rx_byte};
                                end
                            end else begin
                                emit = 1'b1;
                                word = {ev.rx_byte, held_low};
                            end
                            received_bytes = received_bytes + 9'd1;
                        end
                        if (emit) begin
                            r.word_write = 1'b1;
                            r.word_index = idx;
                            r.word_value = word;
                        end
                        if (received_bytes >= expected_bytes) begin
                            r.packet_done = 1'b1;
                            r.packet_kind = KIND_WRITE;
                            phase         = PH_CMD;
                        end
                        if (emit || r.packet_done) begin
                            r.packet_bytes = expected_bytes;
                            r.final_packet = length_nonzero;
                        end
                    end
                    default: begin
                        phase = PH_CMD;
                    end
                endcase
            end
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            errors++;
            if (printed < 100) begin
                printed++;
                $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
            end
        endtask

        task check_field(string what, int unsigned got, int unsigned want);
            if (got != want) begin
                report_mismatch(what, got, want);
            end
        endtask

        task check_result(t_cpr_out got);
            t_cpr_out want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = expected_q.pop_front();
            check_field("tx_load", got.tx_load, want.tx_load);
            check_field("tx_byte", got.tx_byte, want.tx_byte);
            check_field("word_write", got.word_write, want.word_write);
            check_field("word_index", got.word_index, want.word_index);
            check_field("word_value", got.word_value, want.word_value);
            check_field("packet_done", got.packet_done, want.packet_done);
            check_field("packet_kind", got.packet_kind, want.packet_kind);
            check_field("packet_bytes", got.packet_bytes, want.packet_bytes);
            check_field("final_packet", got.final_packet, want.final_packet);
            check_field("command_error", got.command_error, want.command_error);
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_cpr_in                in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_cpr_out               out_data;

    packet_scoreboard       sb;
    bit                     quiet = 1'b0;
    int                     hold_asked = 0;
    int                     hold_done = 0;
    int                     hold_left = 0;
    int                     items_sent = 0;

    command_packet_receiver_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver side: random stalls plus a single long hold-off
    always @(negedge clk) begin
        if (hold_left == 0 && hold_done != hold_asked) begin
            hold_left = 60;
            hold_done++;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (!rst_n || quiet) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < 13);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_data);
        end
    end

    function automatic t_cpr_in rx_event(logic [BYTE_W-1:0] b);
        t_cpr_in ev;
        ev.func       = FUNC_RX_BYTE;
        ev.rx_byte    = b;
        ev.app_status = BYTE_W'($urandom);
        return ev;
    endfunction

    function automatic t_cpr_in tx_empty_event(logic [BYTE_W-1:0] status);
        t_cpr_in ev;
        ev.func       = FUNC_TX_EMPTY;
        ev.rx_byte    = BYTE_W'($urandom);
        ev.app_status = status;
        return ev;
    endfunction

    function automatic logic [BYTE_W-1:0] unknown_command();
        logic [BYTE_W-1:0] b;
        do begin
            b = BYTE_W'($urandom);
        end while (b == sb.write_cmd || b == sb.status_cmd);
        return b;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_item(input t_cpr_in ev);
        while (!quiet && $urandom_range(0, 99) < 13) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sb.accept_event(ev);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_config(input logic [BYTE_W-1:0] wr, input logic [BYTE_W-1:0] st);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WRITE_CMD;
        cfg_data  <= wr;
        @(negedge clk);
        cfg_index <= CFG_STATUS_CMD;
        cfg_data  <= st;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_register(CFG_WRITE_CMD, wr);
        sb.set_register(CFG_STATUS_CMD, st);
    endtask

    task automatic send_packet(input logic [BYTE_W-1:0] len, input bit broken);
        int n;
        int i;
        n = (len == '0) ? 256 : int'(len);
        if (broken) begin
            n = $urandom_range(0, n - 1);
        end
        drive_item(rx_event(sb.write_cmd));
        drive_item(rx_event(len));
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 5) begin
                drive_item(tx_empty_event(BYTE_W'($urandom)));
            end
            drive_item(rx_event(BYTE_W'($urandom)));
        end
    endtask

    initial begin
        int ph;
        int start;
        int pick;
        bit held;
        bit paused;
        logic [BYTE_W-1:0] len;
        sb = new();
        held   = 1'b0;
        paused = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset codes, odd tail, transmit-empty inside a packet
        drive_item(tx_empty_event(8'hFF));
        drive_item(tx_empty_event(8'h00));
        drive_item(rx_event(STATUS_CMD_RESET));
        drive_item(rx_event(8'hFF));
        drive_item(rx_event(8'h00));
        drive_item(rx_event(WRITE_CMD_RESET));
        drive_item(rx_event(8'd3));
        drive_item(rx_event(8'h12));
        drive_item(rx_event(8'h34));
        drive_item(rx_event(8'h56));
        drive_item(rx_event(WRITE_CMD_RESET));
        drive_item(rx_event(8'd2));
        drive_item(rx_event(8'hFF));
        drive_item(tx_empty_event(8'h5C));
        drive_item(rx_event(8'h00));
        drive_item(rx_event(WRITE_CMD_RESET));
        drive_item(rx_event(8'd1));
        drive_item(rx_event(8'h80));
        // equal codes: the write command wins
        wait_drained();
        write_config(8'h80, 8'h80);
        drive_item(rx_event(8'h80));
        drive_item(rx_event(8'd2));
        drive_item(rx_event(8'h00));
        drive_item(rx_event(8'hFF));

        for (ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: write_config(8'h00, 8'hFF);
                1: write_config(8'hFF, 8'h00);
                3: write_config(8'h5A, 8'h5A);
                5: write_config(WRITE_CMD_RESET, STATUS_CMD_RESET);
                default: write_config(BYTE_W'($urandom), BYTE_W'($urandom));
            endcase
            quiet = (ph == 3);
            start = items_sent;
            if (ph == 2) begin
                send_packet(8'd0, 1'b0);
            end
            while (items_sent - start < 50) begin
                if (ph == 1 && !held) begin
                    hold_asked++;
                    held = 1'b1;
                end
                if (ph == 4 && !paused && items_sent - start > 20) begin
                    wait_drained();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    len = ($urandom_range(0, 99) < 4) ? BYTE_W'($urandom_range(10, 255))
                                                     : BYTE_W'($urandom_range(1, 9));
                    send_packet(len, $urandom_range(0, 99) < 5);
                end else if (pick < 70 && sb.status_cmd != sb.write_cmd) begin
                    drive_item(rx_event(sb.status_cmd));
                end else if (pick < 85) begin
                    drive_item(tx_empty_event(BYTE_W'($urandom)));
                end else begin
                    drive_item(rx_event(unknown_command()));
                end
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.pending() != 0) begin
            sb.report_mismatch("results still expected", sb.pending(), 0);
        end
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/cpr_pkg.sv
rtl/cpr_framer.sv
rtl/command_packet_receiver_unit.sv
tb/sv/tb_top.sv
